// ===== rtl/hvn_pkg.sv =====
// ----------------------------------------------------------------------------
// hvn_pkg
// Shared constants, widths and controller/datapath types for the heightmap
// vertex and normal generator.
// ----------------------------------------------------------------------------
`default_nettype none

package hvn_pkg;

  // Tile geometry: interior length and padded row width.
  localparam int TILE_L   = 64;
  localparam int ROW_W    = TILE_L + 2;
  localparam int CNT_W    = 8;
  localparam int ADDR_W   = $clog2(2 * ROW_W);

  // Field and register widths.
  localparam int HGT_W    = 16;
  localparam int SCALE_W  = 24;
  localparam int TILE_W   = 10;
  localparam int CFG_W    = 24;
  localparam int CFG_IDX_W = 2;
  localparam int IDX_W    = 12;
  localparam int POS_W    = 16;
  localparam int PY_W     = 25;
  localparam int COMP_W   = 16;
  localparam int OUT_DATA_W = 184;

  // Arithmetic widths.
  localparam int MUL_W    = 24;
  localparam int PROD_W   = HGT_W + MUL_W;
  localparam int MAG_W    = 31;
  localparam int SQ_W     = 63;
  localparam int LEN_W    = 32;
  localparam int REM_W    = 48;
  localparam int STEP_W   = 5;
  localparam int SQ_STEPS = 32;
  localparam int DIV_STEPS = 16;
  localparam int SEL_W    = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TILE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_Z = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 2'd2;
  localparam logic [SCALE_W-1:0]   SCALE_RESET = 24'd128002;

  // Output component selects for the division pass and length selects.
  localparam logic [SEL_W-1:0] CMP_NX = 3'd0;
  localparam logic [SEL_W-1:0] CMP_NY = 3'd1;
  localparam logic [SEL_W-1:0] CMP_NZ = 3'd2;
  localparam logic [SEL_W-1:0] CMP_TX = 3'd3;
  localparam logic [SEL_W-1:0] CMP_TY = 3'd4;
  localparam logic [SEL_W-1:0] LEN_NORMAL  = 3'd0;
  localparam logic [SEL_W-1:0] LEN_TANGENT = 3'd1;

  // Datapath operations.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_RD_MID,
    OP_RD_L,
    OP_RD_R,
    OP_RD_U,
    OP_CAP_U,
    OP_WRITE,
    OP_MUL_DX,
    OP_MUL_DZ,
    OP_MUL_PY,
    OP_MUL_XH,
    OP_MUL_XM,
    OP_MUL_XL,
    OP_MUL_ZH,
    OP_MUL_ZM,
    OP_MUL_ZL,
    OP_SQ_INIT,
    OP_SQ_STEP,
    OP_SQ_SAVE,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_SAVE,
    OP_LOAD_OUT
  } op_e;

  // Controller states.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_RD_L,
    ST_RD_R,
    ST_RD_U,
    ST_CAP_U,
    ST_WRITE,
    ST_MUL_DX,
    ST_MUL_DZ,
    ST_MUL_PY,
    ST_MUL_XH,
    ST_MUL_XM,
    ST_MUL_XL,
    ST_MUL_ZH,
    ST_MUL_ZM,
    ST_MUL_ZL,
    ST_FLUSH,
    ST_SQ_INIT,
    ST_SQ_STEP,
    ST_SQ_SAVE,
    ST_DIV_INIT,
    ST_DIV_STEP,
    ST_DIV_SAVE,
    ST_OUT
  } state_e;

  typedef struct packed {
    op_e              op;
    logic [SEL_W-1:0] sel;
  } cmd_t;

  typedef struct packed {
    logic emit;
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/hvn_ctrl.sv =====
// ----------------------------------------------------------------------------
// hvn_ctrl
// Sequencer that walks a vertex-making sample through line-store reads,
// multiplies, two square roots and five divisions, and only stores the rest.
// ----------------------------------------------------------------------------
`default_nettype none

module hvn_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire hvn_pkg::sts_t sts_i,
  output hvn_pkg::cmd_t      cmd_o
);

  hvn_pkg::state_e state_q, state_d;
  logic [hvn_pkg::STEP_W-1:0] cnt_q, cnt_d;
  logic [hvn_pkg::SEL_W-1:0]  sel_q, sel_d;

  // State, step counter and component select registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hvn_pkg::ST_IDLE;
      cnt_q   <= '0;
      sel_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      sel_q   <= sel_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    sel_d      = sel_q;
    in_ready_o = 1'b0;
    cmd_o.op   = hvn_pkg::OP_NONE;
    cmd_o.sel  = sel_q;
    unique case (state_q)
      hvn_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = hvn_pkg::OP_ACCEPT;
          state_d  = hvn_pkg::ST_DECIDE;
        end
      end
      hvn_pkg::ST_DECIDE: begin
        if (sts_i.emit) begin
          cmd_o.op = hvn_pkg::OP_RD_MID;
          state_d  = hvn_pkg::ST_RD_L;
        end else begin
          cmd_o.op = hvn_pkg::OP_WRITE;
          state_d  = hvn_pkg::ST_IDLE;
        end
      end
      hvn_pkg::ST_RD_L: begin
        cmd_o.op = hvn_pkg::OP_RD_L;
        state_d  = hvn_pkg::ST_RD_R;
      end
      hvn_pkg::ST_RD_R: begin
        cmd_o.op = hvn_pkg::OP_RD_R;
        state_d  = hvn_pkg::ST_RD_U;
      end
      hvn_pkg::ST_RD_U: begin
        cmd_o.op = hvn_pkg::OP_RD_U;
        state_d  = hvn_pkg::ST_CAP_U;
      end
      hvn_pkg::ST_CAP_U: begin
        cmd_o.op = hvn_pkg::OP_CAP_U;
        state_d  = hvn_pkg::ST_WRITE;
      end
      hvn_pkg::ST_WRITE: begin
        cmd_o.op = hvn_pkg::OP_WRITE;
        state_d  = hvn_pkg::ST_MUL_DX;
      end
      hvn_pkg::ST_MUL_DX: begin
        cmd_o.op = hvn_pkg::OP_MUL_DX;
        state_d  = hvn_pkg::ST_MUL_DZ;
      end
      hvn_pkg::ST_MUL_DZ: begin
        cmd_o.op = hvn_pkg::OP_MUL_DZ;
        state_d  = hvn_pkg::ST_MUL_PY;
      end
      hvn_pkg::ST_MUL_PY: begin
        cmd_o.op = hvn_pkg::OP_MUL_PY;
        state_d  = hvn_pkg::ST_MUL_XH;
      end
      hvn_pkg::ST_MUL_XH: begin
        cmd_o.op = hvn_pkg::OP_MUL_XH;
        state_d  = hvn_pkg::ST_MUL_XM;
      end
      hvn_pkg::ST_MUL_XM: begin
        cmd_o.op = hvn_pkg::OP_MUL_XM;
        state_d  = hvn_pkg::ST_MUL_XL;
      end
      hvn_pkg::ST_MUL_XL: begin
        cmd_o.op = hvn_pkg::OP_MUL_XL;
        state_d  = hvn_pkg::ST_MUL_ZH;
      end
      hvn_pkg::ST_MUL_ZH: begin
        cmd_o.op = hvn_pkg::OP_MUL_ZH;
        state_d  = hvn_pkg::ST_MUL_ZM;
      end
      hvn_pkg::ST_MUL_ZM: begin
        cmd_o.op = hvn_pkg::OP_MUL_ZM;
        state_d  = hvn_pkg::ST_MUL_ZL;
      end
      hvn_pkg::ST_MUL_ZL: begin
        cmd_o.op = hvn_pkg::OP_MUL_ZL;
        state_d  = hvn_pkg::ST_FLUSH;
      end
      hvn_pkg::ST_FLUSH: begin
        sel_d   = hvn_pkg::LEN_NORMAL;
        state_d = hvn_pkg::ST_SQ_INIT;
      end
      hvn_pkg::ST_SQ_INIT: begin
        cmd_o.op = hvn_pkg::OP_SQ_INIT;
        cnt_d    = '0;
        state_d  = hvn_pkg::ST_SQ_STEP;
      end
      hvn_pkg::ST_SQ_STEP: begin
        cmd_o.op = hvn_pkg::OP_SQ_STEP;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == hvn_pkg::STEP_W'(hvn_pkg::SQ_STEPS - 1)) begin
          state_d = hvn_pkg::ST_SQ_SAVE;
        end
      end
      hvn_pkg::ST_SQ_SAVE: begin
        cmd_o.op = hvn_pkg::OP_SQ_SAVE;
        if (sel_q == hvn_pkg::LEN_NORMAL) begin
          sel_d   = hvn_pkg::LEN_TANGENT;
          state_d = hvn_pkg::ST_SQ_INIT;
        end else begin
          sel_d   = hvn_pkg::CMP_NX;
          state_d = hvn_pkg::ST_DIV_INIT;
        end
      end
      hvn_pkg::ST_DIV_INIT: begin
        cmd_o.op = hvn_pkg::OP_DIV_INIT;
        cnt_d    = '0;
        state_d  = hvn_pkg::ST_DIV_STEP;
      end
      hvn_pkg::ST_DIV_STEP: begin
        cmd_o.op = hvn_pkg::OP_DIV_STEP;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == hvn_pkg::STEP_W'(hvn_pkg::DIV_STEPS - 1)) begin
          state_d = hvn_pkg::ST_DIV_SAVE;
        end
      end
      hvn_pkg::ST_DIV_SAVE: begin
        cmd_o.op = hvn_pkg::OP_DIV_SAVE;
        if (sel_q == hvn_pkg::CMP_TY) begin
          state_d = hvn_pkg::ST_OUT;
        end else begin
          sel_d   = sel_q + 1'b1;
          state_d = hvn_pkg::ST_DIV_INIT;
        end
      end
      hvn_pkg::ST_OUT: begin
        // Wait until the output register is free.
        if (!sts_i.out_busy) begin
          cmd_o.op = hvn_pkg::OP_LOAD_OUT;
          state_d  = hvn_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = hvn_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/hvn_dpath.sv =====
// ----------------------------------------------------------------------------
// hvn_dpath
// Line store, tile counters, shared multiplier, square-root and divider
// registers, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hvn_dpath (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire hvn_pkg::cmd_t                  cmd_i,
  output hvn_pkg::sts_t                       sts_o,
  input  wire logic [hvn_pkg::HGT_W-1:0]      height_i,
  input  wire logic                           first_i,
  input  wire logic                           cfg_we_i,
  input  wire logic [hvn_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [hvn_pkg::CFG_W-1:0]      cfg_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [hvn_pkg::OUT_DATA_W-1:0]      out_data_o,
  output logic                                out_last_o
);

  localparam int HW = hvn_pkg::HGT_W;
  localparam int CW = hvn_pkg::CNT_W;
  localparam int AW = hvn_pkg::ADDR_W;

  // Configuration registers.
  logic [hvn_pkg::TILE_W-1:0]  tile_x_q, tile_z_q;
  logic [hvn_pkg::SCALE_W-1:0] scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_x_q <= '0;
      tile_z_q <= '0;
      scale_q  <= hvn_pkg::SCALE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        hvn_pkg::REG_TILE_X: tile_x_q <= cfg_data_i[hvn_pkg::TILE_W-1:0];
        hvn_pkg::REG_TILE_Z: tile_z_q <= cfg_data_i[hvn_pkg::TILE_W-1:0];
        hvn_pkg::REG_SCALE:  scale_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Tile position counters and running extremes.
  logic [CW-1:0] row_q, col_q, cur_r_q, cur_c_q;
  logic [HW-1:0] min_q, max_q, res_min_q, res_max_q;
  logic          emit_q, last_q;
  logic [HW-1:0] h_q, mid_q, hl_q, hr_q, hu_q;
  logic [CW-1:0] acc_r, acc_c;
  logic          acc_emit, acc_last;
  logic [CW:0]   c_inc, r_inc;
  logic [HW-1:0] min_upd, max_upd;

  assign acc_r    = first_i ? '0 : row_q;
  assign acc_c    = first_i ? '0 : col_q;
  assign acc_emit = (acc_r >= CW'(2)) && ({1'b0, acc_r} < (CW+1)'(hvn_pkg::ROW_W)) &&
                    (acc_c >= CW'(1)) && ({1'b0, acc_c} <= (CW+1)'(hvn_pkg::TILE_L));
  assign acc_last = ({1'b0, acc_r} == (CW+1)'(hvn_pkg::ROW_W - 1)) &&
                    ({1'b0, acc_c} == (CW+1)'(hvn_pkg::TILE_L));
  assign c_inc    = {1'b0, cur_c_q} + 1'b1;
  assign r_inc    = {1'b0, cur_r_q} + 1'b1;
  assign min_upd  = (mid_q < min_q) ? mid_q : min_q;
  assign max_upd  = (mid_q > max_q) ? mid_q : max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      col_q  <= '0;
      min_q  <= '1;
      max_q  <= '0;
      emit_q <= 1'b0;
    end else if (cmd_i.op == hvn_pkg::OP_ACCEPT) begin
      emit_q <= acc_emit;
      if (first_i) begin
        min_q <= '1;
        max_q <= '0;
      end
    end else if (cmd_i.op == hvn_pkg::OP_WRITE) begin
      if (emit_q) begin
        min_q <= min_upd;
        max_q <= max_upd;
      end
      if (c_inc >= (CW+1)'(hvn_pkg::ROW_W)) begin
        col_q <= '0;
        if (r_inc >= (CW+1)'(hvn_pkg::ROW_W)) begin
          row_q <= '0;
          min_q <= '1;
          max_q <= '0;
        end else begin
          row_q <= r_inc[CW-1:0];
        end
      end else begin
        col_q <= c_inc[CW-1:0];
        row_q <= cur_r_q;
      end
    end
  end

  // Per-item sample registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == hvn_pkg::OP_ACCEPT) begin
      h_q     <= height_i;
      cur_r_q <= acc_r;
      cur_c_q <= acc_c;
      last_q  <= acc_last;
    end
    if (cmd_i.op == hvn_pkg::OP_WRITE && emit_q) begin
      res_min_q <= min_upd;
      res_max_q <= max_upd;
    end
  end

  // Line store: two rows, one read and one write port, registered read.
  logic [HW-1:0] mem [2*hvn_pkg::ROW_W];
  logic [HW-1:0] rdata_q;
  logic [AW-1:0] cur_base, prev_base, raddr, waddr;
  logic [AW-1:0] col_a;

  assign col_a     = AW'(cur_c_q);
  assign cur_base  = cur_r_q[0] ? AW'(hvn_pkg::ROW_W) : '0;
  assign prev_base = cur_r_q[0] ? '0 : AW'(hvn_pkg::ROW_W);
  assign waddr     = cur_base + col_a;

  always_comb begin
    unique case (cmd_i.op)
      hvn_pkg::OP_RD_L: raddr = prev_base + col_a - 1'b1;
      hvn_pkg::OP_RD_R: raddr = prev_base + col_a + 1'b1;
      hvn_pkg::OP_RD_U: raddr = cur_base + col_a;
      default:          raddr = prev_base + col_a;
    endcase
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr];
    if (cmd_i.op == hvn_pkg::OP_WRITE) begin
      mem[waddr] <= h_q;
    end
  end

  // Capture the neighborhood as the reads return.
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      hvn_pkg::OP_RD_L:  mid_q <= rdata_q;
      hvn_pkg::OP_RD_R:  hl_q  <= rdata_q;
      hvn_pkg::OP_RD_U:  hr_q  <= rdata_q;
      hvn_pkg::OP_CAP_U: hu_q  <= rdata_q;
      default: ;
    endcase
  end

  // Shared multiplier with a registered product; the tag tells what to do
  // with the product in the following cycle.
  localparam int MW = hvn_pkg::MUL_W;
  localparam int PW = hvn_pkg::PROD_W;
  localparam int VW = hvn_pkg::MAG_W;
  localparam int SW = hvn_pkg::SQ_W;

  logic [HW-1:0] mul_a;
  logic [MW-1:0] mul_b;
  logic [PW-1:0] prod_q;
  hvn_pkg::op_e  tag_q;
  logic [VW-1:0] dx_q, dz_q;
  logic          nx_q, nz_q;
  logic [HW-1:0] diff_x, diff_z;
  logic [VW-1:0] sq_sel;

  assign diff_x = (hr_q >= hl_q) ? (hr_q - hl_q) : (hl_q - hr_q);
  assign diff_z = (h_q >= hu_q) ? (h_q - hu_q) : (hu_q - h_q);

  always_comb begin
    sq_sel = dx_q;
    if (cmd_i.op == hvn_pkg::OP_MUL_ZH || cmd_i.op == hvn_pkg::OP_MUL_ZM ||
        cmd_i.op == hvn_pkg::OP_MUL_ZL) begin
      sq_sel = dz_q;
    end
    unique case (cmd_i.op)
      hvn_pkg::OP_MUL_DX: begin
        mul_a = diff_x;
        mul_b = scale_q;
      end
      hvn_pkg::OP_MUL_DZ: begin
        mul_a = diff_z;
        mul_b = scale_q;
      end
      hvn_pkg::OP_MUL_PY: begin
        mul_a = mid_q;
        mul_b = scale_q;
      end
      hvn_pkg::OP_MUL_XH, hvn_pkg::OP_MUL_ZH: begin
        mul_a = HW'(sq_sel[VW-1:16]);
        mul_b = MW'(sq_sel[VW-1:16]);
      end
      hvn_pkg::OP_MUL_XM, hvn_pkg::OP_MUL_ZM: begin
        mul_a = HW'(sq_sel[VW-1:16]);
        mul_b = MW'(sq_sel[15:0]);
      end
      default: begin
        mul_a = sq_sel[15:0];
        mul_b = MW'(sq_sel[15:0]);
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= hvn_pkg::OP_NONE;
    end else begin
      tag_q <= cmd_i.op;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= PW'(mul_a) * PW'(mul_b);
  end

  // Rounded Q.16 magnitude of a product and its saturation.
  logic [32:0]         rnd;
  logic [VW-1:0]       mag_sat;
  logic [SW-1:0]       acc_q, xt_q, acc_sum;
  logic [hvn_pkg::PY_W-1:0] py_q;

  assign rnd     = 33'((41'(prod_q) + 41'd128) >> 8);
  assign mag_sat = (rnd > 33'h7FFF_FFFF) ? '1 : rnd[VW-1:0];

  always_comb begin
    unique case (tag_q)
      hvn_pkg::OP_MUL_XH, hvn_pkg::OP_MUL_ZH: acc_sum = acc_q + (SW'(prod_q[29:0]) << 32);
      hvn_pkg::OP_MUL_XM, hvn_pkg::OP_MUL_ZM: acc_sum = acc_q + (SW'(prod_q[30:0]) << 17);
      default:                                acc_sum = acc_q + SW'(prod_q[31:0]);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == hvn_pkg::OP_MUL_DX) begin
      acc_q <= SW'(1) << 32;
    end
    unique case (tag_q)
      hvn_pkg::OP_MUL_DX: begin
        dx_q <= mag_sat;
        nx_q <= (hr_q < hl_q) && (mag_sat != '0);
      end
      hvn_pkg::OP_MUL_DZ: begin
        dz_q <= mag_sat;
        nz_q <= (h_q < hu_q) && (mag_sat != '0);
      end
      hvn_pkg::OP_MUL_PY: begin
        py_q <= (rnd > 33'h1FF_FFFF) ? '1 : rnd[hvn_pkg::PY_W-1:0];
      end
      hvn_pkg::OP_MUL_XH, hvn_pkg::OP_MUL_XM, hvn_pkg::OP_MUL_ZH,
      hvn_pkg::OP_MUL_ZM, hvn_pkg::OP_MUL_ZL: begin
        acc_q <= acc_sum;
      end
      hvn_pkg::OP_MUL_XL: begin
        acc_q <= acc_sum;
        xt_q  <= acc_sum;
      end
      default: ;
    endcase
  end

  // Bit-by-bit integer square root, one result bit per step.
  logic [SW-1:0] sq_x_q, sq_res_q, sq_bit_q, sq_try;
  logic [hvn_pkg::LEN_W-1:0] rn_q, rt_q;

  assign sq_try = sq_res_q + sq_bit_q;

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      hvn_pkg::OP_SQ_INIT: begin
        sq_x_q   <= (cmd_i.sel == hvn_pkg::LEN_NORMAL) ? acc_q : xt_q;
        sq_res_q <= '0;
        sq_bit_q <= SW'(1) << (SW - 1);
      end
      hvn_pkg::OP_SQ_STEP: begin
        if (sq_x_q >= sq_try) begin
          sq_x_q   <= sq_x_q - sq_try;
          sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
        end else begin
          sq_res_q <= sq_res_q >> 1;
        end
        sq_bit_q <= sq_bit_q >> 2;
      end
      hvn_pkg::OP_SQ_SAVE: begin
        if (cmd_i.sel == hvn_pkg::LEN_NORMAL) begin
          rn_q <= sq_res_q[hvn_pkg::LEN_W-1:0];
        end else begin
          rt_q <= sq_res_q[hvn_pkg::LEN_W-1:0];
        end
      end
      default: ;
    endcase
  end

  // Restoring divider for the Q1.15 components, one quotient bit a step.
  localparam int RW = hvn_pkg::REM_W;
  localparam int QW = hvn_pkg::COMP_W;

  logic [RW-1:0] rem_q, dv_q;
  logic [QW-1:0] q_q;
  logic          neg_q, div_neg;
  logic [VW-1:0] div_v;
  logic [hvn_pkg::LEN_W-1:0] div_len;
  logic [QW-2:0] q_mag;
  logic [QW-1:0] q_signed;
  logic [QW-1:0] nxo_q, nyo_q, nzo_q, txo_q, tyo_q;

  always_comb begin
    unique case (cmd_i.sel)
      hvn_pkg::CMP_NX: begin
        div_v = dx_q; div_len = rn_q; div_neg = !nx_q && (dx_q != '0);
      end
      hvn_pkg::CMP_NY: begin
        div_v = VW'(1) << 16; div_len = rn_q; div_neg = 1'b0;
      end
      hvn_pkg::CMP_NZ: begin
        div_v = dz_q; div_len = rn_q; div_neg = !nz_q && (dz_q != '0);
      end
      hvn_pkg::CMP_TX: begin
        div_v = VW'(1) << 16; div_len = rt_q; div_neg = 1'b0;
      end
      default: begin
        div_v = dx_q; div_len = rt_q; div_neg = nx_q;
      end
    endcase
  end

  assign q_mag    = q_q[QW-1] ? '1 : q_q[QW-2:0];
  assign q_signed = neg_q ? (QW'(0) - {1'b0, q_mag}) : {1'b0, q_mag};

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      hvn_pkg::OP_DIV_INIT: begin
        rem_q <= (RW'(div_v) << 15) + RW'(div_len[hvn_pkg::LEN_W-1:1]);
        dv_q  <= RW'(div_len) << 15;
        q_q   <= '0;
        neg_q <= div_neg;
      end
      hvn_pkg::OP_DIV_STEP: begin
        if (rem_q >= dv_q) begin
          rem_q <= rem_q - dv_q;
          q_q   <= {q_q[QW-2:0], 1'b1};
        end else begin
          q_q   <= {q_q[QW-2:0], 1'b0};
        end
        dv_q <= dv_q >> 1;
      end
      hvn_pkg::OP_DIV_SAVE: begin
        unique case (cmd_i.sel)
          hvn_pkg::CMP_NX: nxo_q <= q_signed;
          hvn_pkg::CMP_NY: nyo_q <= q_signed;
          hvn_pkg::CMP_NZ: nzo_q <= q_signed;
          hvn_pkg::CMP_TX: txo_q <= q_signed;
          default:         tyo_q <= q_signed;
        endcase
      end
      default: ;
    endcase
  end

  // Vertex coordinates from the tile position.
  logic [15:0] vidx_w, posx_w, posz_w;

  assign vidx_w = (16'(cur_r_q) - 16'd2) * 16'(hvn_pkg::TILE_L) + 16'(cur_c_q) - 16'd1;
  assign posx_w = 16'(tile_x_q) * 16'(hvn_pkg::TILE_L - 1) + 16'(cur_c_q);
  assign posz_w = 16'(tile_z_q) * 16'(hvn_pkg::TILE_L - 1) + 16'(cur_r_q) - 16'd1;

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.op == hvn_pkg::OP_LOAD_OUT) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == hvn_pkg::OP_LOAD_OUT) begin
      out_last_o <= last_q;
      out_data_o <= {3'b000,
                     last_q ? res_max_q : 16'd0,
                     last_q ? res_min_q : 16'd0,
                     tyo_q, txo_q, nzo_q, nyo_q, nxo_q,
                     posz_w[hvn_pkg::POS_W-1:0], py_q,
                     posx_w[hvn_pkg::POS_W-1:0], vidx_w[hvn_pkg::IDX_W-1:0]};
    end
  end

  assign sts_o.emit     = emit_q;
  assign sts_o.out_busy = out_valid_o && !out_ready_i;

endmodule

`default_nettype wire

// ===== rtl/heightmap_vertex_normal_gen_unit.sv =====
// ----------------------------------------------------------------------------
// heightmap_vertex_normal_gen_unit
// Turns a padded height tile into vertices with positions, normals, tangents.
// ----------------------------------------------------------------------------
// Usage: samples of one (L+2) by (L+2) tile arrive row-major on the s_axis
// channel; tdata holds the 16-bit height and tuser marks the first sample of a
// tile. Each interior point yields one vertex item on the m_axis channel once
// the sample below it arrives; tlast marks the final vertex, which also
// carries the tile's minimum and maximum interior height.
// A sample that makes no vertex is accepted and written to the line store. A
// sample that makes a vertex is accepted, then passes through the line-store
// reads and write, the shared multiplier, the square-root unit (32 steps for
// each of two lengths), the divider (16 steps for each of five components)
// and the load of the output register; only then is the next sample taken.
// The vertex appears on m_axis the cycle after that load.
// The output register holds a finished vertex while the receiver stalls; the
// block takes the next sample meanwhile and waits only if a second vertex is
// ready before the first has gone.
// Reset clears the tile counters, the running extremes and the output valid,
// and restores the default configuration. The user must write configuration
// via cfg_we_i, cfg_idx_i, cfg_data_i only while idle; the block does not check.
// ----------------------------------------------------------------------------
`default_nettype none

module heightmap_vertex_normal_gen_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [hvn_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [hvn_pkg::CFG_W-1:0]     cfg_data_i,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // height [15:0]
  input  wire logic [hvn_pkg::HGT_W-1:0]     s_axis_tdata,
  // first [0]
  input  wire logic                          s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // vertex_index [11:0], pos_x [27:12], pos_y [52:28], pos_z [68:53],
  // normal_x [84:69], normal_y [100:85], normal_z [116:101],
  // tangent_x [132:117], tangent_y [148:133], min_height [164:149],
  // max_height [180:165], zero fill [183:181]
  output logic [hvn_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  output logic                               m_axis_tlast
);

  hvn_pkg::cmd_t cmd;
  hvn_pkg::sts_t sts;

  hvn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  hvn_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .height_i    (s_axis_tdata),
    .first_i     (s_axis_tuser),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

`default_nettype wire

// ===== rtl/hvn_checker.sv =====
// ----------------------------------------------------------------------------
// hvn_checker
// Port-level checks of the vertex generator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hvn_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          cfg_we_i,
  input wire logic [hvn_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input wire logic [hvn_pkg::CFG_W-1:0]     cfg_data_i,
  input wire logic                          s_axis_tvalid,
  input wire logic                          s_axis_tready,
  input wire logic [hvn_pkg::HGT_W-1:0]     s_axis_tdata,
  input wire logic                          s_axis_tuser,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [hvn_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input wire logic                          m_axis_tlast
);

  // One sample is worked on at a time.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a sample is in progress");

  // A stalled vertex is held.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled vertex changed");

  // The y component of the normal and x of the tangent are never negative.
  a_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !m_axis_tdata[100] && !m_axis_tdata[132])
    else $error("negative normal_y or tangent_x");

  // Extremes are only shown on the last vertex.
  a_extremes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[180:149] == 32'd0)
    else $error("extremes on a vertex that is not last");

endmodule

bind heightmap_vertex_normal_gen_unit hvn_checker u_hvn_checker (.*);

`default_nettype wire
